// File: sv/jqet_pkg.sv
// Shared types and constants for the quintic Julia escape-time engine.
// Holds the item structs, the configuration register map and the sequencer states.
// No dependencies.
package jqet_pkg;

    // Fixed field widths of the item and configuration interfaces.
    localparam int PIXEL_BITS = 12;
    localparam int STEP_W     = 31;
    localparam int OFF_W      = PIXEL_BITS + STEP_W;
    localparam int ITER_W     = 16;
    localparam int DIST_W     = 31;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Reset values of the configuration registers.
    localparam logic signed [31:0] RST_C_RE     = -32'sd13254001;
    localparam logic signed [31:0] RST_C_IM     = 32'sd2516582;
    localparam logic signed [31:0] RST_X_MIN    = -32'sd33554432;
    localparam logic signed [31:0] RST_Y_MIN    = -32'sd26843546;
    localparam logic [STEP_W-1:0]  RST_X_STEP   = 31'd65536;
    localparam logic [STEP_W-1:0]  RST_Y_STEP   = 31'd69905;
    localparam logic [30:0]        RST_BAILOUT  = 31'd67108864;
    localparam logic [ITER_W-1:0]  RST_MAX_ITER = 16'd1000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C_RE     = 3'd0,
        REG_C_IM     = 3'd1,
        REG_X_MIN    = 3'd2,
        REG_Y_MIN    = 3'd3,
        REG_X_STEP   = 3'd4,
        REG_Y_STEP   = 3'd5,
        REG_BAILOUT  = 3'd6,
        REG_MAX_ITER = 3'd7
    } cfg_reg_t;

    // One input item: a pixel position and the band marker.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_x;
        logic [PIXEL_BITS-1:0] pixel_y;
        logic                  last_in_band;
    } pixel_in_t;

    // One result item.
    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic              escaped;
        logic [DIST_W-1:0] final_distance;
        logic              last_out;
    } pixel_out_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PIX_X,
        ST_PIX_Y,
        ST_COORD_Y,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_TEST,
        ST_Z2_X,
        ST_Z4_RR,
        ST_Z4_II,
        ST_Z4_X,
        ST_Z5_A,
        ST_Z5_B,
        ST_Z5_C,
        ST_Z5_D,
        ST_ADD_C,
        ST_FINISH
    } state_t;

endpackage

// File: sv/jqet_mul.sv
// Shared fixed-point multiplier: sign-magnitude product built from 32x32 partial
// products in turn, shifted by the fraction width and saturated.
// No package dependencies.
module jqet_mul #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] op_a,
    input  logic signed [COORD_WIDTH-1:0] op_b,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] prod,
    output logic [31:0]                   prod_clip
);

    localparam int W    = COORD_WIDTH;
    localparam int NCH  = (W + 31) / 32;
    localparam int MW   = 32 * NCH;
    localparam int ACCW = 2 * MW;

    localparam logic [W-1:0]    CMAX_U = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]    CMIN_U = {1'b1, {(W-1){1'b0}}};
    localparam logic [ACCW-1:0] CMAX_A = ACCW'(CMAX_U);
    localparam logic [ACCW-1:0] TWO31  = ACCW'(1) << 31;

    logic [W-1:0]    ua;
    logic [W-1:0]    ub;
    logic [W-1:0]    mag_a;
    logic [W-1:0]    mag_b;
    logic [MW-1:0]   a_mag_reg;
    logic [MW-1:0]   b_mag_reg;
    logic            neg_reg;
    logic [0:0]      ia_reg;
    logic [0:0]      ib_reg;
    logic            issue_reg;
    logic            last_issue;
    logic [31:0]     a_chunk;
    logic [31:0]     b_chunk;
    logic [63:0]     pp_reg;
    logic [1:0]      pp_sh_reg;
    logic            pp_vld_reg;
    logic            pp_last_reg;
    logic [ACCW-1:0] acc_reg;
    logic            fin_reg;
    logic            done_reg;
    logic [ACCW-1:0] shr;
    logic            big;
    logic [W-1:0]    low;
    logic [W-1:0]    prod_next;
    logic [31:0]     clip_next;
    logic [W-1:0]    prod_reg;
    logic [31:0]     clip_reg;

    // Operand magnitudes; the most negative value maps onto its unsigned magnitude.
    assign ua    = op_a;
    assign ub    = op_b;
    assign mag_a = ua[W-1] ? (~ua + 1'b1) : ua;
    assign mag_b = ub[W-1] ? (~ub + 1'b1) : ub;

    // Current 32-bit digits of each magnitude.
    assign a_chunk    = 32'(a_mag_reg >> (32 * ia_reg));
    assign b_chunk    = 32'(b_mag_reg >> (32 * ib_reg));
    assign last_issue = (ia_reg == 1'(NCH - 1)) && (ib_reg == 1'(NCH - 1));

    // Scale and saturate the finished product.
    always_comb begin
        shr  = acc_reg >> FRAC_BITS;
        big  = shr > CMAX_A;
        low  = shr[W-1:0];
        if (big) begin
            prod_next = neg_reg ? CMIN_U : CMAX_U;
        end else begin
            prod_next = neg_reg ? (~low + 1'b1) : low;
        end
        clip_next = (shr >= TWO31) ? 32'h8000_0000 : shr[31:0];
    end

    // Control: digit counters and the valid marks that follow the partial products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg   <= 1'b0;
            ia_reg      <= '0;
            ib_reg      <= '0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            fin_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            pp_vld_reg  <= issue_reg;
            pp_last_reg <= issue_reg && last_issue;
            fin_reg     <= pp_vld_reg && pp_last_reg;
            done_reg    <= fin_reg;
            if (start) begin
                issue_reg <= 1'b1;
                ia_reg    <= '0;
                ib_reg    <= '0;
            end else if (issue_reg) begin
                if (last_issue) begin
                    issue_reg <= 1'b0;
                end
                if (ib_reg == 1'(NCH - 1)) begin
                    ib_reg <= '0;
                    ia_reg <= ia_reg + 1'b1;
                end else begin
                    ib_reg <= ib_reg + 1'b1;
                end
            end
        end
    end

    // Datapath: one partial product per cycle, registered, then accumulated.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_mag_reg <= MW'(mag_a);
            b_mag_reg <= MW'(mag_b);
            neg_reg   <= op_a[W-1] ^ op_b[W-1];
            acc_reg   <= '0;
        end else if (pp_vld_reg) begin
            acc_reg <= acc_reg + (ACCW'(pp_reg) << (32 * pp_sh_reg));
        end
        pp_reg    <= a_chunk * b_chunk;
        pp_sh_reg <= {1'b0, ia_reg} + {1'b0, ib_reg};
        if (fin_reg) begin
            prod_reg <= prod_next;
            clip_reg <= clip_next;
        end
    end

    assign done      = done_reg;
    assign prod      = prod_reg;
    assign prod_clip = clip_reg;

endmodule

// File: sv/julia_quintic_escape_time.sv
// Top level of the quintic Julia escape-time engine: registers, sequencer and datapath.
// Depends on jqet_pkg and jqet_mul.
//
//   Port group    Direction  Handshake              Payload
//   s_*           in         s_valid / s_ready      jqet_pkg::pixel_in_t
//   m_*           out        m_valid / m_ready      jqet_pkg::pixel_out_t
//   cfg_*         in         cfg_wr_en (no wait)    cfg_index, cfg_wr_data
//
// Every iteration multiply goes through the one shared multiplier; the pixel offset has
// its own small multiplier. One iteration is ten multiplies plus the test and add-c states.
// Reset is synchronous, active low, and leaves the block idle with the registers at
// their defaults. A new item is taken while a finished result still waits; the
// block then holds its next result until m_ready frees the output register.
module julia_quintic_escape_time #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  jqet_pkg::pixel_in_t                    s_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output jqet_pkg::pixel_out_t                   m_item,
    input  logic                                   cfg_wr_en,
    input  logic [jqet_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [jqet_pkg::CFG_DATA_W-1:0]        cfg_wr_data
);

    localparam int W   = COORD_WIDTH;
    localparam int W1  = W + 1;
    localparam int OW  = jqet_pkg::OFF_W;
    localparam int DW  = jqet_pkg::DIST_W;
    localparam int XW  = ((W > 32) ? W : 32) + 1;
    localparam int CW  = ((OW > W) ? OW : W) + 1;
    localparam int DXW = (W > 32) ? W : 32;

    localparam logic signed [W-1:0]  CMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  CMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [XW-1:0] CMAX_X = XW'(CMAX);
    localparam logic signed [XW-1:0] CMIN_X = XW'(CMIN);
    localparam logic [CW-1:0]        CMAX_C = CW'(CMAX);
    localparam logic [DXW-1:0]       DMAX_X = DXW'(jqet_pkg::DIST_MAX);

    // Saturate a one-bit-grown sum to the coordinate range.
    function automatic logic signed [W-1:0] sat_w(input logic signed [W1-1:0] v);
        logic signed [W-1:0] r;
        if (v[W] != v[W-1]) begin
            r = v[W] ? CMIN : CMAX;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        return sat_w(W1'(a) + W1'(b));
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        return sat_w(W1'(a) - W1'(b));
    endfunction

    // Clamp a value that may come from a 32-bit register into the coordinate range.
    function automatic logic signed [W-1:0] clamp_x(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v > CMAX_X) begin
            r = CMAX;
        end else if (v < CMIN_X) begin
            r = CMIN;
        end else begin
            r = W'(v);
        end
        return r;
    endfunction

    // Configuration registers.
    logic signed [31:0]               c_re_reg;
    logic signed [31:0]               c_im_reg;
    logic signed [31:0]               x_min_reg;
    logic signed [31:0]               y_min_reg;
    logic [jqet_pkg::STEP_W-1:0]      x_step_reg;
    logic [jqet_pkg::STEP_W-1:0]      y_step_reg;
    logic [30:0]                      bailout_reg;
    logic [jqet_pkg::ITER_W-1:0]      max_iter_reg;

    // Item state.
    jqet_pkg::state_t                 state_reg;
    jqet_pkg::state_t                 state_next;
    logic                             wait_reg;
    logic                             wait_next;
    logic [jqet_pkg::PIXEL_BITS-1:0]  px_reg;
    logic [jqet_pkg::PIXEL_BITS-1:0]  py_reg;
    logic                             last_reg;
    logic [OW-1:0]                    off_reg;
    logic signed [W-1:0]              re_reg;
    logic signed [W-1:0]              im_reg;
    logic signed [W-1:0]              p_re_reg;
    logic signed [W-1:0]              p_im_reg;
    logic signed [W-1:0]              t0_reg;
    logic signed [W-1:0]              t1_reg;
    logic signed [W-1:0]              t2_reg;
    logic [31:0]                      mag0_reg;
    logic [31:0]                      mag1_reg;
    logic                             esc_reg;
    logic [jqet_pkg::ITER_W-1:0]      it_reg;
    logic                             m_valid_reg;
    jqet_pkg::pixel_out_t             m_item_reg;

    // Combinational signals.
    logic                             accept;
    logic                             mul_state;
    logic                             mul_start;
    logic                             mul_done;
    logic signed [W-1:0]              mul_a;
    logic signed [W-1:0]              mul_b;
    logic signed [W-1:0]              mul_prod;
    logic [31:0]                      mul_clip;
    logic                             out_load;
    logic                             esc_now;
    logic                             at_limit;
    logic [OW-1:0]                    pix_prod;
    logic [CW-1:0]                    off_ext;
    logic signed [W-1:0]              off_clip;
    logic signed [31:0]               coord_base;
    logic signed [W-1:0]              coord;
    logic signed [W-1:0]              sum_ri;
    logic [W-1:0]                     sum_u;
    logic [W-1:0]                     sum_mag;
    logic [DXW-1:0]                   sum_mag_x;
    logic [DW-1:0]                    dist_sat;

    assign accept = s_valid && s_ready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_re_reg     <= jqet_pkg::RST_C_RE;
            c_im_reg     <= jqet_pkg::RST_C_IM;
            x_min_reg    <= jqet_pkg::RST_X_MIN;
            y_min_reg    <= jqet_pkg::RST_Y_MIN;
            x_step_reg   <= jqet_pkg::RST_X_STEP;
            y_step_reg   <= jqet_pkg::RST_Y_STEP;
            bailout_reg  <= jqet_pkg::RST_BAILOUT;
            max_iter_reg <= jqet_pkg::RST_MAX_ITER;
        end else if (cfg_wr_en) begin
            case (jqet_pkg::cfg_reg_t'(cfg_index))
                jqet_pkg::REG_C_RE:     c_re_reg     <= cfg_wr_data;
                jqet_pkg::REG_C_IM:     c_im_reg     <= cfg_wr_data;
                jqet_pkg::REG_X_MIN:    x_min_reg    <= cfg_wr_data;
                jqet_pkg::REG_Y_MIN:    y_min_reg    <= cfg_wr_data;
                jqet_pkg::REG_X_STEP:   x_step_reg   <= cfg_wr_data[30:0];
                jqet_pkg::REG_Y_STEP:   y_step_reg   <= cfg_wr_data[30:0];
                jqet_pkg::REG_BAILOUT:  bailout_reg  <= cfg_wr_data[30:0];
                jqet_pkg::REG_MAX_ITER: max_iter_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier.
    jqet_mul #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mul_start),
        .op_a      (mul_a),
        .op_b      (mul_b),
        .done      (mul_done),
        .prod      (mul_prod),
        .prod_clip (mul_clip)
    );

    // Pixel offset: one small multiplier shared by both axes, clipped to the range.
    assign pix_prod   = (state_reg == jqet_pkg::ST_PIX_X)
                      ? OW'(px_reg) * OW'(x_step_reg)
                      : OW'(py_reg) * OW'(y_step_reg);
    assign off_ext    = CW'(off_reg);
    assign off_clip   = (off_ext > CMAX_C) ? CMAX : W'(off_ext);
    assign coord_base = (state_reg == jqet_pkg::ST_PIX_Y) ? x_min_reg : y_min_reg;
    assign coord      = sat_add(clamp_x(XW'(coord_base)), off_clip);

    // Escape test from the two clipped squares.
    assign esc_now  = (33'(mag0_reg) + 33'(mag1_reg)) > 33'(bailout_reg);
    assign at_limit = it_reg >= max_iter_reg;

    // Final distance: |re + im| capped to the result field.
    assign sum_ri    = sat_add(re_reg, im_reg);
    assign sum_u     = sum_ri;
    assign sum_mag   = sum_u[W-1] ? (~sum_u + 1'b1) : sum_u;
    assign sum_mag_x = DXW'(sum_mag);
    assign dist_sat  = (sum_mag_x > DMAX_X) ? jqet_pkg::DIST_MAX
                                            : DW'(sum_mag_x);

    // Sequencer: next state, input ready, result load, multiplier operands and launch.
    always_comb begin
        state_next = state_reg;
        mul_state  = 1'b0;
        mul_a      = re_reg;
        mul_b      = im_reg;
        out_load   = 1'b0;
        s_ready    = (state_reg == jqet_pkg::ST_IDLE);
        case (state_reg)
            jqet_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = jqet_pkg::ST_PIX_X;
                end
            end
            jqet_pkg::ST_PIX_X:   state_next = jqet_pkg::ST_PIX_Y;
            jqet_pkg::ST_PIX_Y:   state_next = jqet_pkg::ST_COORD_Y;
            jqet_pkg::ST_COORD_Y: state_next = jqet_pkg::ST_SQ_RE;
            jqet_pkg::ST_SQ_RE: begin
                mul_state = 1'b1;
                mul_a     = re_reg;
                mul_b     = re_reg;
                if (mul_done) state_next = jqet_pkg::ST_SQ_IM;
            end
            jqet_pkg::ST_SQ_IM: begin
                mul_state = 1'b1;
                mul_a     = im_reg;
                mul_b     = im_reg;
                if (mul_done) state_next = jqet_pkg::ST_TEST;
            end
            jqet_pkg::ST_TEST: begin
                if (esc_now || at_limit) begin
                    state_next = jqet_pkg::ST_FINISH;
                end else begin
                    state_next = jqet_pkg::ST_Z2_X;
                end
            end
            jqet_pkg::ST_Z2_X: begin
                mul_state = 1'b1;
                mul_a     = re_reg;
                mul_b     = im_reg;
                if (mul_done) state_next = jqet_pkg::ST_Z4_RR;
            end
            jqet_pkg::ST_Z4_RR: begin
                mul_state = 1'b1;
                mul_a     = p_re_reg;
                mul_b     = p_re_reg;
                if (mul_done) state_next = jqet_pkg::ST_Z4_II;
            end
            jqet_pkg::ST_Z4_II: begin
                mul_state = 1'b1;
                mul_a     = p_im_reg;
                mul_b     = p_im_reg;
                if (mul_done) state_next = jqet_pkg::ST_Z4_X;
            end
            jqet_pkg::ST_Z4_X: begin
                mul_state = 1'b1;
                mul_a     = p_re_reg;
                mul_b     = p_im_reg;
                if (mul_done) state_next = jqet_pkg::ST_Z5_A;
            end
            jqet_pkg::ST_Z5_A: begin
                mul_state = 1'b1;
                mul_a     = p_re_reg;
                mul_b     = re_reg;
                if (mul_done) state_next = jqet_pkg::ST_Z5_B;
            end
            jqet_pkg::ST_Z5_B: begin
                mul_state = 1'b1;
                mul_a     = p_im_reg;
                mul_b     = im_reg;
                if (mul_done) state_next = jqet_pkg::ST_Z5_C;
            end
            jqet_pkg::ST_Z5_C: begin
                mul_state = 1'b1;
                mul_a     = p_re_reg;
                mul_b     = im_reg;
                if (mul_done) state_next = jqet_pkg::ST_Z5_D;
            end
            jqet_pkg::ST_Z5_D: begin
                mul_state = 1'b1;
                mul_a     = p_im_reg;
                mul_b     = re_reg;
                if (mul_done) state_next = jqet_pkg::ST_ADD_C;
            end
            jqet_pkg::ST_ADD_C:   state_next = jqet_pkg::ST_SQ_RE;
            jqet_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = jqet_pkg::ST_IDLE;
                end
            end
            default: state_next = jqet_pkg::ST_IDLE;
        endcase
        mul_start = mul_state && !wait_reg;
        wait_next = mul_start || (wait_reg && !mul_done);
    end

    // State and handshake registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= jqet_pkg::ST_IDLE;
            wait_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            m_valid_reg <= out_load || (m_valid_reg && !m_ready);
        end
    end

    // Datapath registers, loaded on accept, on result load and by state.
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg   <= s_item.pixel_x;
            py_reg   <= s_item.pixel_y;
            last_reg <= s_item.last_in_band;
        end
        if (out_load) begin
            m_item_reg.iterations     <= it_reg;
            m_item_reg.escaped        <= esc_reg;
            m_item_reg.final_distance <= dist_sat;
            m_item_reg.last_out       <= last_reg;
        end
        case (state_reg)
            jqet_pkg::ST_PIX_X: begin
                off_reg <= pix_prod;
            end
            jqet_pkg::ST_PIX_Y: begin
                re_reg  <= coord;
                off_reg <= pix_prod;
            end
            jqet_pkg::ST_COORD_Y: begin
                im_reg <= coord;
                it_reg <= '0;
            end
            jqet_pkg::ST_SQ_RE, jqet_pkg::ST_Z4_RR, jqet_pkg::ST_Z5_A: begin
                if (mul_done) begin
                    t0_reg   <= mul_prod;
                    mag0_reg <= mul_clip;
                end
            end
            jqet_pkg::ST_SQ_IM, jqet_pkg::ST_Z4_II, jqet_pkg::ST_Z5_B: begin
                if (mul_done) begin
                    t1_reg   <= mul_prod;
                    mag1_reg <= mul_clip;
                end
            end
            jqet_pkg::ST_TEST: begin
                esc_reg <= esc_now;
            end
            jqet_pkg::ST_Z2_X, jqet_pkg::ST_Z4_X: begin
                // Squaring: real part from the two squares, imaginary part doubled.
                if (mul_done) begin
                    p_re_reg <= sat_sub(t0_reg, t1_reg);
                    p_im_reg <= sat_add(mul_prod, mul_prod);
                end
            end
            jqet_pkg::ST_Z5_C: begin
                if (mul_done) begin
                    t2_reg <= mul_prod;
                end
            end
            jqet_pkg::ST_Z5_D: begin
                if (mul_done) begin
                    p_re_reg <= sat_sub(t0_reg, t1_reg);
                    p_im_reg <= sat_add(t2_reg, mul_prod);
                end
            end
            jqet_pkg::ST_ADD_C: begin
                re_reg <= clamp_x(XW'(p_re_reg) + XW'(c_re_reg));
                im_reg <= clamp_x(XW'(p_im_reg) + XW'(c_im_reg));
                it_reg <= it_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: sv/jqet_checker.sv
// Port-level checks for the quintic Julia escape-time engine, bound to its top level.
// Depends on jqet_pkg and julia_quintic_escape_time.
module jqet_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input jqet_pkg::pixel_out_t m_item,
    input logic                 m_valid,
    input logic                 m_ready
);

    // A stalled result keeps its valid.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_item))
        else $error("result payload changed while stalled");

    // An accepted item occupies the engine for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an item was accepted");

    // Reset leaves the engine idle and empty.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("engine not idle after reset");

endmodule

bind julia_quintic_escape_time jqet_checker u_jqet_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_item  (m_item),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
